// ----- hdl/mi3_pkg.sv -----
// shared constants, cofactor index tables and width helper for the 3x3 inverse
// no dependencies
`timescale 1ns / 1ps
package mi3_pkg;

	localparam int MI3_ELEM_WIDTH = 32;
	localparam int MI3_FRAC_BITS  = 16;

	// adjugate entry k (row-major), i.e. the cofactor of the transposed position, = a[P]*a[Q] - a[R]*a[S]
	localparam int COF_P [9] = '{4, 7, 1, 5, 0, 2, 3, 1, 0};
	localparam int COF_Q [9] = '{8, 2, 5, 6, 8, 3, 7, 6, 4};
	localparam int COF_R [9] = '{7, 1, 4, 3, 2, 0, 4, 0, 1};
	localparam int COF_S [9] = '{5, 8, 2, 8, 6, 5, 6, 7, 3};

	// round a bit count up to whole bytes
	function automatic int pad8(input int n);
		return ((n + 7) >> 3) << 3;
	endfunction

endpackage

// ----- hdl/mi3_cof.sv -----
// two-stage cofactor unit: 18 element products, then nine differences
// depends on mi3_pkg
`timescale 1ns / 1ps
module mi3_cof #(
	parameter int ELEM_WIDTH = mi3_pkg::MI3_ELEM_WIDTH
) (
	input  logic                                 clk,
	input  logic                                 en,
	input  logic [8:0][ELEM_WIDTH-1:0]           a,
	output logic [8:0][2*ELEM_WIDTH:0]           cof
);
	localparam int PW = 2 * ELEM_WIDTH;

	logic [8:0][PW-1:0] pq_s1;
	logic [8:0][PW-1:0] rs_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 9; k++) begin
				pq_s1[k] <= $signed(a[mi3_pkg::COF_P[k]]) * $signed(a[mi3_pkg::COF_Q[k]]);
				rs_s1[k] <= $signed(a[mi3_pkg::COF_R[k]]) * $signed(a[mi3_pkg::COF_S[k]]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 9; k++) begin
				cof[k] <= {pq_s1[k][PW-1], pq_s1[k]} - {rs_s1[k][PW-1], rs_s1[k]};
			end
		end
	end

endmodule

// ----- hdl/mi3_det.sv -----
// three-stage determinant along the first column, products split in halves
// depends on mi3_pkg
`timescale 1ns / 1ps
module mi3_det #(
	parameter int ELEM_WIDTH = mi3_pkg::MI3_ELEM_WIDTH
) (
	input  logic                               clk,
	input  logic                               en,
	input  logic [2:0][ELEM_WIDTH-1:0]         col,
	input  logic [2:0][2*ELEM_WIDTH:0]         cof,
	output logic [3*ELEM_WIDTH+2:0]            det
);
	localparam int EW = ELEM_WIDTH;
	localparam int PW = 2 * EW + 1;
	localparam int TW = 3 * EW + 1;

	logic [2:0][PW-1:0] lo_s1;
	logic [2:0][PW-1:0] hi_s1;
	logic [2:0][TW-1:0] term_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				lo_s1[j] <= $signed(col[j]) * $signed({1'b0, cof[j][EW-1:0]});
				hi_s1[j] <= $signed(col[j]) * $signed(cof[j][2*EW:EW]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				term_s2[j] <= {hi_s1[j], {EW{1'b0}}} + {{EW{lo_s1[j][PW-1]}}, lo_s1[j]};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			det <= {{2{term_s2[0][TW-1]}}, term_s2[0]}
				+ {{2{term_s2[1][TW-1]}}, term_s2[1]}
				+ {{2{term_s2[2][TW-1]}}, term_s2[2]};
		end
	end

endmodule

// ----- hdl/mi3_div.sv -----
// pipelined restoring divider lane: (cofactor << 2*frac) / det, saturated
// one quotient bit per stage; depends on mi3_pkg
`timescale 1ns / 1ps
module mi3_div #(
	parameter int ELEM_WIDTH = mi3_pkg::MI3_ELEM_WIDTH,
	parameter int FRAC_BITS  = mi3_pkg::MI3_FRAC_BITS
) (
	input  logic                        clk,
	input  logic                        en,
	input  logic [2*ELEM_WIDTH:0]       cof,
	input  logic [3*ELEM_WIDTH+2:0]     det,
	output logic [ELEM_WIDTH-1:0]       res,
	output logic                        clip
);
	localparam int EW = ELEM_WIDTH;
	localparam int CW = 2 * EW + 1;
	localparam int DW = 3 * EW + 3;
	localparam int NW = CW + 2 * FRAC_BITS;
	localparam int RW = (NW > DW + EW) ? NW : DW + EW;

	logic [CW-1:0] magc_s1;
	logic [DW-1:0] magd_s1;
	logic          neg_s1;

	logic [RW-1:0] rem_s  [EW+1];
	logic [EW-1:0] quo_s  [EW+1];
	logic [DW-1:0] den_s  [EW+1];
	logic          neg_s  [EW+1];
	logic          ovf_s  [EW+1];

	logic [RW-1:0] num;
	logic          qclip;
	logic [EW-1:0] qfin;

	always_ff @(posedge clk) begin
		if (en) begin
			magc_s1 <= cof[CW-1] ? (~cof + CW'(1)) : cof;
			magd_s1 <= det[DW-1] ? (~det + DW'(1)) : det;
			neg_s1  <= cof[CW-1] ^ det[DW-1];
		end
	end

	assign num = RW'({magc_s1, {(2 * FRAC_BITS){1'b0}}});

	// quotient must fit below 2^EW or the element clips
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= num;
			quo_s[0] <= '0;
			den_s[0] <= magd_s1;
			neg_s[0] <= neg_s1;
			ovf_s[0] <= num >= (RW'(magd_s1) << EW);
		end
	end

	for (genvar k = 0; k < EW; k++) begin : g_step
		logic [RW-1:0] sub;
		assign sub = RW'(den_s[k]) << (EW - 1 - k);
		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_s[k] >= sub) begin
					rem_s[k+1] <= rem_s[k] - sub;
					quo_s[k+1] <= quo_s[k] | (EW'(1) << (EW - 1 - k));
				end else begin
					rem_s[k+1] <= rem_s[k];
					quo_s[k+1] <= quo_s[k];
				end
				den_s[k+1] <= den_s[k];
				neg_s[k+1] <= neg_s[k];
				ovf_s[k+1] <= ovf_s[k];
			end
		end
	end

	assign qfin  = quo_s[EW];
	assign qclip = ovf_s[EW]
		|| (qfin[EW-1] && (!neg_s[EW] || (|qfin[EW-2:0])));

	always_ff @(posedge clk) begin
		if (en) begin
			clip <= qclip;
			if (qclip) begin
				res <= neg_s[EW] ? {1'b1, {(EW-1){1'b0}}} : {1'b0, {(EW-1){1'b1}}};
			end else begin
				res <= neg_s[EW] ? (~qfin + EW'(1)) : qfin;
			end
		end
	end

endmodule

// ----- hdl/matrix_inverse_3x3_unit.sv -----
// top level of the 3x3 fixed-point matrix inverse (adjugate over determinant)
// depends on mi3_pkg, mi3_cof, mi3_det, mi3_div
`timescale 1ns / 1ps
// Takes one matrix per cycle and returns its inverse after the cofactor stages,
// the determinant stages and the nine divider lanes, which produce one quotient
// bit per stage, plus the output register. The whole pipeline holds while a
// result waits on m_tready, so throughput is one matrix per cycle whenever the
// sink keeps up.
// A zero determinant returns the input matrix with singular set.
module matrix_inverse_3x3_unit #(
	parameter int ELEM_WIDTH = mi3_pkg::MI3_ELEM_WIDTH,
	parameter int FRAC_BITS  = mi3_pkg::MI3_FRAC_BITS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// a00, a01, a02, a10, a11, a12, a20, a21, a22 from bit 0 up, zero padded
	input  logic [mi3_pkg::pad8(9*ELEM_WIDTH)-1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// b00, b01, b02, b10, b11, b12, b20, b21, b22 from bit 0 up, zero padded
	output logic [mi3_pkg::pad8(9*ELEM_WIDTH)-1:0] m_tdata,
	// singular, clipped from bit 0 up
	output logic [1:0] m_tuser
);
	localparam int EW  = ELEM_WIDTH;
	localparam int DW  = 3 * EW + 3;
	localparam int TDW = mi3_pkg::pad8(9 * EW);
	localparam int LAT = EW + 9;
	localparam int ADL = EW + 8;
	localparam int SDL = EW + 3;

	logic                    en;
	logic [LAT-1:0]          vld_q;
	logic [8:0][EW-1:0]      a_in;
	logic [8:0][2*EW:0]      cof;
	logic [8:0][2*EW:0]      cof_s [3];
	logic [DW-1:0]           det;
	logic [8:0][EW-1:0]      a_s   [ADL];
	logic                    sing_s [SDL];
	logic [8:0][EW-1:0]      res;
	logic [8:0]              clip;
	logic [8:0][EW-1:0]      out_s;
	logic                    sing_out_s;
	logic                    clip_out_s;

	assign en       = !vld_q[LAT-1] || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], s_tvalid};
		end
	end

	for (genvar k = 0; k < 9; k++) begin : g_unpack
		assign a_in[k] = s_tdata[k*EW +: EW];
	end

	mi3_cof #(.ELEM_WIDTH(EW)) u_cof (
		.clk (clk),
		.en  (en),
		.a   (a_in),
		.cof (cof)
	);

	// first column for the determinant: a00, a10, a20 taken from a_s[1], in step with the cofactors
	mi3_det #(.ELEM_WIDTH(EW)) u_det (
		.clk (clk),
		.en  (en),
		.col ({a_s[1][6], a_s[1][3], a_s[1][0]}),
		.cof ({cof[2], cof[1], cof[0]}),
		.det (det)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			cof_s[0] <= cof;
			cof_s[1] <= cof_s[0];
			cof_s[2] <= cof_s[1];
			a_s[0]   <= a_in;
			for (int i = 1; i < ADL; i++) a_s[i] <= a_s[i-1];
			sing_s[0] <= det == '0;
			for (int i = 1; i < SDL; i++) sing_s[i] <= sing_s[i-1];
		end
	end

	for (genvar k = 0; k < 9; k++) begin : g_lane
		mi3_div #(.ELEM_WIDTH(EW), .FRAC_BITS(FRAC_BITS)) u_div (
			.clk  (clk),
			.en   (en),
			.cof  (cof_s[2][k]),
			.det  (det),
			.res  (res[k]),
			.clip (clip[k])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sing_out_s <= sing_s[SDL-1];
			out_s      <= sing_s[SDL-1] ? a_s[ADL-1] : res;
			clip_out_s <= !sing_s[SDL-1] && (|clip);
		end
	end

	assign m_tdata = TDW'(out_s);
	assign m_tuser = {clip_out_s, sing_out_s};

endmodule

// ----- hdl/mi3_checker.sv -----
// port-level checks for matrix_inverse_3x3_unit, bound onto the top level
// depends on mi3_pkg and matrix_inverse_3x3_unit
`timescale 1ns / 1ps
module mi3_checker #(
	parameter int ELEM_WIDTH = mi3_pkg::MI3_ELEM_WIDTH
) (
	input logic clk,
	input logic arst_n,
	input logic s_tready,
	input logic m_tvalid,
	input logic m_tready,
	input logic [mi3_pkg::pad8(9*ELEM_WIDTH)-1:0] m_tdata,
	input logic [1:0] m_tuser
);
	// a held result keeps its value
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// input side only stalls behind a held result
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without output backpressure");

	// a singular matrix never reports saturation
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
		else $error("singular and clipped both set");

	// a held result keeps the input side stalled until the sink takes it
	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> !s_tready || m_tready)
		else $error("pipeline advanced past a held result");

endmodule

bind matrix_inverse_3x3_unit mi3_checker #(.ELEM_WIDTH(ELEM_WIDTH)) u_mi3_checker (.*);

// ----- dv/matrix_inverse_3x3_checker.sv -----
// checker for the 3x3 matrix inverse: watches both streams, predicts each inverse
// depends on mi3_pkg
`timescale 1ns / 1ps
module matrix_inverse_3x3_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	input  logic s_tready,
	// a00..a22 from bit 0 up
	input  logic [mi3_pkg::pad8(9*mi3_pkg::MI3_ELEM_WIDTH)-1:0] s_tdata,
	input  logic m_tvalid,
	input  logic m_tready,
	// b00..b22 from bit 0 up
	input  logic [mi3_pkg::pad8(9*mi3_pkg::MI3_ELEM_WIDTH)-1:0] m_tdata,
	// singular, clipped from bit 0 up
	input  logic [1:0] m_tuser,
	output int   fail_count,
	output int   pending
);
	localparam int EW = mi3_pkg::MI3_ELEM_WIDTH;
	localparam int TW = mi3_pkg::pad8(9*EW);

	typedef struct packed {
		logic [TW-1:0] elems;
		logic          singular;
		logic          clipped;
	} inverse_t;

	inverse_t expected_inverses[$];

	// exact adjugate over determinant, per-element divide with saturation
	function automatic inverse_t compute_inverse(input logic [TW-1:0] mat);
		inverse_t res;
		logic signed [EW-1:0] a [9];
		logic signed [2*EW+1:0] cof [9];
		logic signed [3*EW+3:0] det, num, quo;
		logic signed [3*EW+3:0] hi, lo;
		int k;
		res = '0;
		for (k = 0; k < 9; k++) a[k] = mat[k*EW +: EW];
		hi = (1 <<< (EW-1)) - 1;
		lo = -(1 <<< (EW-1));
		for (k = 0; k < 9; k++) begin
			cof[k] = ($signed({{(EW+2){a[mi3_pkg::COF_P[k]][EW-1]}}, a[mi3_pkg::COF_P[k]]})
				* $signed({{(EW+2){a[mi3_pkg::COF_Q[k]][EW-1]}}, a[mi3_pkg::COF_Q[k]]}))
				- ($signed({{(EW+2){a[mi3_pkg::COF_R[k]][EW-1]}}, a[mi3_pkg::COF_R[k]]})
				* $signed({{(EW+2){a[mi3_pkg::COF_S[k]][EW-1]}}, a[mi3_pkg::COF_S[k]]}));
		end
		det = a[0]*cof[0] + a[3]*cof[1] + a[6]*cof[2];
		if (det == 0) begin
			res.elems = mat;
			res.singular = 1'b1;
			return res;
		end
		for (k = 0; k < 9; k++) begin
			num = cof[k];
			num = num <<< (2*mi3_pkg::MI3_FRAC_BITS);
			quo = num / det; // truncates toward zero
			if (quo > hi) begin
				quo = hi;
				res.clipped = 1'b1;
			end else if (quo < lo) begin
				quo = lo;
				res.clipped = 1'b1;
			end
			res.elems[k*EW +: EW] = quo[EW-1:0];
		end
		return res;
	endfunction

	assign pending = expected_inverses.size();

	always @(posedge clk or negedge arst_n) begin
		inverse_t exp_r;
		int k;
		int errs;
		if (!arst_n) begin
			fail_count <= 0;
			expected_inverses.delete();
		end else begin
			errs = 0;
			if (s_tvalid && s_tready) expected_inverses.push_back(compute_inverse(s_tdata));
			if (m_tvalid && m_tready) begin
				if (expected_inverses.size() == 0) begin
					$error("result with no request outstanding");
					errs = errs + 1;
				end else begin
					exp_r = expected_inverses.pop_front();
					for (k = 0; k < 9; k++)
						if (m_tdata[k*EW +: EW] !== exp_r.elems[k*EW +: EW]) begin
							$error("b%0d%0d expected %h actual %h", k/3, k%3,
								exp_r.elems[k*EW +: EW], m_tdata[k*EW +: EW]);
							errs = errs + 1;
						end
					if (m_tuser[0] !== exp_r.singular) begin
						$error("singular expected %b actual %b", exp_r.singular, m_tuser[0]);
						errs = errs + 1;
					end
					if (m_tuser[1] !== exp_r.clipped) begin
						$error("clipped expected %b actual %b", exp_r.clipped, m_tuser[1]);
						errs = errs + 1;
					end
				end
			end
			fail_count <= fail_count + errs;
		end
	end
endmodule

// ----- dv/matrix_inverse_3x3_unit_tb.sv -----
// stimulus and verdict for the 3x3 matrix inverse
// depends on mi3_pkg, matrix_inverse_3x3_unit, matrix_inverse_3x3_checker
`timescale 1ns / 1ps
module matrix_inverse_3x3_unit_tb;
	localparam int EW = mi3_pkg::MI3_ELEM_WIDTH;
	localparam int TW = mi3_pkg::pad8(9*EW);
	localparam int ONE = 1 << mi3_pkg::MI3_FRAC_BITS;
	localparam int STALL_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [TW-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [TW-1:0] m_tdata;
	logic [1:0] m_tuser;
	int fail_count, pending;
	int send_idle_pct = 0, sink_stall_pct = 0;
	bit hold_sink = 1'b0;
	int quiet_cycles = 0;

	always #10 clk = ~clk;

	matrix_inverse_3x3_unit i_dut (.*);
	matrix_inverse_3x3_checker i_chk (.*);

	// sink: random stalls, or a long hold-off when asked
	always @(posedge clk)
		m_tready <= !hold_sink && ($urandom_range(99) >= sink_stall_pct);

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > STALL_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic logic [EW-1:0] rand_elem();
		case ($urandom_range(5))
			0: return $urandom;
			1: return {$urandom_range(1) ? 16'hffff : 16'h0, 16'($urandom)};
			2: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
			3: return 32'($signed($urandom_range(8)) - 4) * ONE;
			default: return 32'($signed({{16{1'b0}}, 16'($urandom)}) - 32768) <<< 4;
		endcase
	endfunction

	// leaves tvalid high after the accepting edge; the caller drops it when done
	task automatic send_matrix(input logic [TW-1:0] mat);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= mat;
		do @(posedge clk); while (!s_tready);
	endtask

	function automatic logic [TW-1:0] pack9(input logic [EW-1:0] e [9]);
		logic [TW-1:0] m;
		int k;
		m = '0;
		for (k = 0; k < 9; k++) m[k*EW +: EW] = e[k];
		return m;
	endfunction

	task automatic send_random(input int n);
		logic [EW-1:0] e [9];
		int i, k;
		for (i = 0; i < n; i++) begin
			for (k = 0; k < 9; k++) e[k] = rand_elem();
			// some singular matrices: a copied row
			if ($urandom_range(9) == 0) for (k = 0; k < 3; k++) e[6+k] = e[k];
			send_matrix(pack9(e));
		end
	endtask

	initial begin
		logic [EW-1:0] e [9];
		int k, n;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// identity, scaled identities, zero, extremes
		e = '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE};
		send_matrix(pack9(e));
		e = '{2*ONE, 0, 0, 0, -4*ONE, 0, 0, 0, ONE/2};
		send_matrix(pack9(e));
		e = '{1, 0, 0, 0, 1, 0, 0, 0, 1}; // tiny: saturates
		send_matrix(pack9(e));
		e = '{-1, 0, 0, 0, 1, 0, 0, 0, -1};
		send_matrix(pack9(e));
		for (k = 0; k < 9; k++) e[k] = 0;
		send_matrix(pack9(e));
		for (k = 0; k < 9; k++) e[k] = 32'hffffffff;
		send_matrix(pack9(e));
		e = '{32'h80000000, 0, 0, 0, 32'h80000000, 0, 0, 0, 32'h80000000};
		send_matrix(pack9(e));
		e = '{32'h7fffffff, 0, 0, 0, 32'h7fffffff, 0, 0, 0, 32'h7fffffff};
		send_matrix(pack9(e));
		e = '{32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
			32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000};
		send_matrix(pack9(e));
		e = '{32'haaaaaaaa, 32'h55555555, 1, 32'h55555555, 32'haaaaaaaa, 2, 3, 4,
			32'h12345678};
		send_matrix(pack9(e));
		e = '{ONE, 2*ONE, 3*ONE, 4*ONE, 5*ONE, 6*ONE, 7*ONE, 8*ONE, 9*ONE}; // singular
		send_matrix(pack9(e));
		e = '{0, ONE, 0, ONE, 0, 0, 0, 0, ONE}; // zero pivot in a00
		send_matrix(pack9(e));
		// long receiver hold-off while the sender keeps offering
		fork
			begin
				hold_sink = 1'b1;
				repeat (300) @(posedge clk);
				hold_sink = 1'b0;
			end
			send_random(80);
		join
		s_tvalid <= 1'b0;
		@(posedge clk);
		// sender pauses until every result has come
		while (pending != 0) @(posedge clk);
		for (n = 0; n < 4; n++) begin
			case (n)
				0: begin send_idle_pct = 0;  sink_stall_pct = 0;  end
				1: begin send_idle_pct = 65; sink_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  sink_stall_pct = 65; end
				default: begin send_idle_pct = 29; sink_stall_pct = 29; end
			endcase
			send_random(130);
		end
		s_tvalid <= 1'b0;
		sink_stall_pct = 0;
		while (pending != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
